// ----- design/imugd_pkg.sv -----
// ----------------------------------------------------------------------------
// imugd_pkg
// Shared types, constants and rounding helpers for the gradient-descent
// orientation filter.
// ----------------------------------------------------------------------------
package imugd_pkg;

  localparam int QUAT_FRAC_BITS_DEF = 30;
  localparam int QW                 = 32;
  localparam int CFG_ADDR_W         = 2;
  localparam int CFG_DATA_W         = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_GAIN_BETA     = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_PERIOD = 2'd1;

  localparam logic [31:0] GAIN_BETA_RST     = 32'd26843546;
  localparam logic [31:0] SAMPLE_PERIOD_RST = 32'd4294967;

  localparam logic signed [67:0] ONE_Q30 = 68'sd1073741824;

  typedef logic [3:0][63:0] vec4_t;
  typedef logic [3:0][31:0] quat_t;

  typedef struct packed {
    logic done;
    logic ok;
  } ut_stat_t;

  typedef enum logic [2:0] {
    U_IDLE,
    U_SCALE,
    U_SQ,
    U_ROOT,
    U_DSET,
    U_DIV,
    U_DONE
  } ut_state_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACC_GO,
    S_ACC_WAIT,
    S_MAC,
    S_GRAD_GO,
    S_GRAD_WAIT,
    S_NQ_GO,
    S_NQ_WAIT,
    S_OUT
  } gd_state_t;

  function automatic logic [63:0] mag64(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  // right shift rounding half away from zero
  function automatic logic signed [67:0] rsr68(input logic signed [67:0] v,
                                               input int unsigned n);
    logic [67:0] m;
    logic [67:0] half;
    m    = v[67] ? (68'd0 - v) : v;
    half = (n == 0) ? 68'd0 : (68'd1 << (n - 1));
    m    = (m + half) >> n;
    return v[67] ? $signed(68'd0 - m) : $signed(m);
  endfunction

endpackage

// ----- design/imugd_if.sv -----
// ----------------------------------------------------------------------------
// imugd_in_if / imugd_out_if
// Valid/ready channels for imu samples and orientation results.
// ----------------------------------------------------------------------------
interface imugd_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] gyro_x;
  logic signed [31:0] gyro_y;
  logic signed [31:0] gyro_z;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  modport source(output valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
                 input ready);
  modport sink(input valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
               output ready);
endinterface

interface imugd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] quat_w;
  logic signed [31:0] quat_x;
  logic signed [31:0] quat_y;
  logic signed [31:0] quat_z;
  logic               correction_skipped;
  modport source(output valid, quat_w, quat_x, quat_y, quat_z, correction_skipped,
                 input ready);
  modport sink(input valid, quat_w, quat_x, quat_y, quat_z, correction_skipped,
               output ready);
endinterface

// ----- design/imu_gradient_descent_orientation.sv -----
// ----------------------------------------------------------------------------
// imu_gradient_descent_orientation
// Gradient-descent orientation filter over one shared multiplier and one
// shared normalization unit.
// ----------------------------------------------------------------------------
// usage:
//   in_if carries one imu sample per item: three gyro rates (q8.24 rad/s)
//   and three raw accelerometer counts. out_if returns one orientation
//   quaternion per item plus a flag set when the correction was skipped.
//   cfg_we/cfg_addr/cfg_wdata write gain_beta (index 0) and sample_period
//   (index 1); the user must write them only while the block is idle (not enforced).
// operation:
//   one item at a time. each item passes through the normalization unit
//   up to three times; each pass does a scaling search, a 32-step square
//   root and four divides. the multiply steps run on the shared 34x34
//   multiplier. the gradient pass and its multiply steps are skipped when
//   the accelerometer is zero, and a zero gradient ends the gradient pass
//   early.
// reset:
//   orientation returns to the unit quaternion, registers to their defaults.
// stall:
//   the result waits in the output register; a new item is taken once the
//   previous result has been registered, and the next result waits until
//   the receiver takes the pending one.
// ----------------------------------------------------------------------------
module imu_gradient_descent_orientation #(
  parameter int QUAT_FRAC_BITS = imugd_pkg::QUAT_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  imugd_in_if.sink                         in_if,
  imugd_out_if.source                      out_if,
  input  logic                             cfg_we,
  input  logic [imugd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [imugd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import imugd_pkg::*;

  localparam int QSH = 30 - QUAT_FRAC_BITS;
  localparam logic signed [31:0] QMAX = 32'(64'sd1 <<< QUAT_FRAC_BITS);

  gd_state_t state_r, state_nxt;

  logic [31:0]        beta_r, dt_r;
  logic signed [31:0] orient_r [4];
  logic signed [31:0] q_r [4];
  logic signed [31:0] w_r [3];
  logic signed [15:0] acc_in_r [3];
  logic signed [31:0] a_r [4];
  logic signed [31:0] gh_r [4];
  logic signed [33:0] f_r [3];
  logic signed [63:0] g_r [4];
  logic signed [63:0] d_r [4];
  logic signed [63:0] nq_r [4];
  logic signed [63:0] e_r;
  logic signed [67:0] prod_r, acc_r;
  logic [5:0]         step_r;
  logic               phase_r;
  logic               skip_r;
  logic               out_valid_r;
  logic signed [31:0] out_q_r [4];
  logic               out_skip_r;

  logic signed [33:0] mul_a, mul_b;
  logic [63:0]        emag;
  logic signed [67:0] r30, r28, tdt;
  logic signed [63:0] tdt_s;
  logic               ut_start;
  vec4_t              ut_vec;
  quat_t              ut_un;
  ut_stat_t           ut_stat;
  logic               out_free;

  imugd_unitize u_unit (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (ut_start),
    .vec_in (ut_vec),
    .un     (ut_un),
    .stat   (ut_stat)
  );

  assign emag     = mag64(e_r);
  assign r30      = rsr68(prod_r, 30);
  assign r28      = rsr68(prod_r, 28);
  assign tdt      = (acc_r + 68'sd32768 + (prod_r >>> 16)) >>> 16;
  assign tdt_s    = e_r[63] ? 64'(-tdt) : 64'(tdt);
  assign out_free = !out_valid_r || out_if.ready;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (step_r)
      6'd0:  begin mul_a = 34'(q_r[1]); mul_b = 34'(q_r[3]); end
      6'd1:  begin mul_a = 34'(q_r[0]); mul_b = 34'(q_r[2]); end
      6'd2:  begin mul_a = 34'(q_r[0]); mul_b = 34'(q_r[1]); end
      6'd3:  begin mul_a = 34'(q_r[2]); mul_b = 34'(q_r[3]); end
      6'd4:  begin mul_a = 34'(q_r[1]); mul_b = 34'(q_r[1]); end
      6'd5:  begin mul_a = 34'(q_r[2]); mul_b = 34'(q_r[2]); end
      6'd6:  begin mul_a = 34'(q_r[1]); mul_b = f_r[1]; end
      6'd7:  begin mul_a = 34'(q_r[2]); mul_b = f_r[0]; end
      6'd8:  begin mul_a = 34'(q_r[3]); mul_b = f_r[0]; end
      6'd9:  begin mul_a = 34'(q_r[0]); mul_b = f_r[1]; end
      6'd10: begin mul_a = 34'(q_r[1]); mul_b = f_r[2]; end
      6'd11: begin mul_a = 34'(q_r[3]); mul_b = f_r[1]; end
      6'd12: begin mul_a = 34'(q_r[2]); mul_b = f_r[2]; end
      6'd13: begin mul_a = 34'(q_r[0]); mul_b = f_r[0]; end
      6'd14: begin mul_a = 34'(q_r[1]); mul_b = f_r[0]; end
      6'd15: begin mul_a = 34'(q_r[2]); mul_b = f_r[1]; end
      6'd16: begin mul_a = 34'(q_r[1]); mul_b = 34'(w_r[0]); end
      6'd17: begin mul_a = 34'(q_r[2]); mul_b = 34'(w_r[1]); end
      6'd18: begin mul_a = 34'(q_r[3]); mul_b = 34'(w_r[2]); end
      6'd19: begin mul_a = 34'(q_r[0]); mul_b = 34'(w_r[0]); end
      6'd20: begin mul_a = 34'(q_r[2]); mul_b = 34'(w_r[2]); end
      6'd21: begin mul_a = 34'(q_r[3]); mul_b = 34'(w_r[1]); end
      6'd22: begin mul_a = 34'(q_r[0]); mul_b = 34'(w_r[1]); end
      6'd23: begin mul_a = 34'(q_r[1]); mul_b = 34'(w_r[2]); end
      6'd24: begin mul_a = 34'(q_r[3]); mul_b = 34'(w_r[0]); end
      6'd25: begin mul_a = 34'(q_r[0]); mul_b = 34'(w_r[2]); end
      6'd26: begin mul_a = 34'(q_r[1]); mul_b = 34'(w_r[1]); end
      6'd27: begin mul_a = 34'(q_r[2]); mul_b = 34'(w_r[0]); end
      6'd28: begin mul_a = {2'b00, beta_r}; mul_b = 34'(gh_r[0]); end
      6'd31: begin mul_a = {2'b00, beta_r}; mul_b = 34'(gh_r[1]); end
      6'd34: begin mul_a = {2'b00, beta_r}; mul_b = 34'(gh_r[2]); end
      6'd37: begin mul_a = {2'b00, beta_r}; mul_b = 34'(gh_r[3]); end
      6'd29, 6'd32, 6'd35, 6'd38: begin
        mul_a = {1'b0, emag[48:16]};
        mul_b = {2'b00, dt_r};
      end
      6'd30, 6'd33, 6'd36, 6'd39: begin
        mul_a = {18'd0, emag[15:0]};
        mul_b = {2'b00, dt_r};
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:      if (in_if.valid) state_nxt = S_ACC_GO;
      S_ACC_GO:    state_nxt = S_ACC_WAIT;
      S_ACC_WAIT:  if (ut_stat.done) state_nxt = S_MAC;
      S_MAC: begin
        if (phase_r && step_r == 6'd15) state_nxt = S_GRAD_GO;
        else if (phase_r && step_r == 6'd39) state_nxt = S_NQ_GO;
      end
      S_GRAD_GO:   state_nxt = S_GRAD_WAIT;
      S_GRAD_WAIT: if (ut_stat.done) state_nxt = S_MAC;
      S_NQ_GO:     state_nxt = S_NQ_WAIT;
      S_NQ_WAIT:   if (ut_stat.done) state_nxt = S_OUT;
      S_OUT:       if (out_free) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_if.ready = (state_r == S_IDLE);
    ut_start    = (state_r == S_ACC_GO) || (state_r == S_GRAD_GO) || (state_r == S_NQ_GO);
    for (int k = 0; k < 4; k++) begin
      ut_vec[k] = nq_r[k];
    end
    if (state_r == S_ACC_GO) begin
      for (int k = 0; k < 3; k++) ut_vec[k] = 64'(acc_in_r[k]);
      ut_vec[3] = 64'd0;
    end else if (state_r == S_GRAD_GO) begin
      for (int k = 0; k < 4; k++) ut_vec[k] = g_r[k];
    end
    out_if.valid              = out_valid_r;
    out_if.quat_w             = out_q_r[0];
    out_if.quat_x             = out_q_r[1];
    out_if.quat_y             = out_q_r[2];
    out_if.quat_z             = out_q_r[3];
    out_if.correction_skipped = out_skip_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      beta_r      <= GAIN_BETA_RST;
      dt_r        <= SAMPLE_PERIOD_RST;
      orient_r[0] <= QMAX;
      orient_r[1] <= 32'sd0;
      orient_r[2] <= 32'sd0;
      orient_r[3] <= 32'sd0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_GAIN_BETA:     beta_r <= cfg_wdata;
          REG_SAMPLE_PERIOD: dt_r   <= cfg_wdata;
          default: ;
        endcase
      end
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_NQ_WAIT && ut_stat.done && ut_stat.ok) begin
        for (int k = 0; k < 4; k++) begin
          if ($signed(ut_un[k]) > 32'sd1073741824) begin
            orient_r[k] <= 32'(rsr68(ONE_Q30, QSH));
          end else if ($signed(ut_un[k]) < -32'sd1073741824) begin
            orient_r[k] <= 32'(rsr68(-ONE_Q30, QSH));
          end else begin
            orient_r[k] <= 32'(rsr68(68'($signed(ut_un[k])), QSH));
          end
        end
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_if.valid) begin
          for (int k = 0; k < 4; k++) begin
            q_r[k]  <= 32'(orient_r[k] <<< QSH);
            gh_r[k] <= 32'sd0;
          end
          w_r[0]      <= in_if.gyro_x;
          w_r[1]      <= in_if.gyro_y;
          w_r[2]      <= in_if.gyro_z;
          acc_in_r[0] <= in_if.accel_x;
          acc_in_r[1] <= in_if.accel_y;
          acc_in_r[2] <= in_if.accel_z;
          skip_r      <= 1'b1;
        end
      end
      S_ACC_WAIT: begin
        if (ut_stat.done) begin
          for (int k = 0; k < 4; k++) a_r[k] <= $signed(ut_un[k]);
          step_r  <= ut_stat.ok ? 6'd0 : 6'd16;
          phase_r <= 1'b0;
        end
      end
      S_GRAD_WAIT: begin
        if (ut_stat.done) begin
          if (ut_stat.ok) begin
            for (int k = 0; k < 4; k++) gh_r[k] <= $signed(ut_un[k]);
            skip_r <= 1'b0;
          end
          step_r  <= 6'd16;
          phase_r <= 1'b0;
        end
      end
      S_MAC: begin
        phase_r <= ~phase_r;
        if (!phase_r) begin
          prod_r <= mul_a * mul_b;
        end else begin
          step_r <= step_r + 6'd1;
          unique case (step_r)
            6'd0, 6'd2, 6'd4, 6'd16, 6'd19, 6'd22, 6'd25,
            6'd29, 6'd32, 6'd35, 6'd38: acc_r <= prod_r;
            6'd1:  f_r[0] <= 34'(rsr68(acc_r - prod_r, 29) - 68'(a_r[0]));
            6'd3:  f_r[1] <= 34'(rsr68(acc_r + prod_r, 29) - 68'(a_r[1]));
            6'd5:  f_r[2] <= 34'(ONE_Q30 - rsr68(acc_r + prod_r, 29) - 68'(a_r[2]));
            6'd6, 6'd8, 6'd11, 6'd14: acc_r <= r30 <<< 1;
            6'd7:  g_r[0] <= 64'(acc_r - (r30 <<< 1));
            6'd9:  acc_r  <= acc_r + (r30 <<< 1);
            6'd10: g_r[1] <= 64'(acc_r - (r30 <<< 2));
            6'd12: acc_r  <= acc_r - (r30 <<< 2);
            6'd13: g_r[2] <= 64'(acc_r - (r30 <<< 1));
            6'd15: g_r[3] <= 64'(acc_r + (r30 <<< 1));
            6'd17, 6'd20, 6'd26: acc_r <= acc_r + prod_r;
            6'd23: acc_r <= acc_r - prod_r;
            6'd18: d_r[0] <= 64'(-rsr68(acc_r + prod_r, 25));
            6'd21: d_r[1] <= 64'(rsr68(acc_r - prod_r, 25));
            6'd24: d_r[2] <= 64'(rsr68(acc_r + prod_r, 25));
            6'd27: d_r[3] <= 64'(rsr68(acc_r - prod_r, 25));
            6'd28: e_r <= d_r[0] - 64'(r28);
            6'd31: e_r <= d_r[1] - 64'(r28);
            6'd34: e_r <= d_r[2] - 64'(r28);
            6'd37: e_r <= d_r[3] - 64'(r28);
            6'd30: nq_r[0] <= 64'(q_r[0]) + tdt_s;
            6'd33: nq_r[1] <= 64'(q_r[1]) + tdt_s;
            6'd36: nq_r[2] <= 64'(q_r[2]) + tdt_s;
            6'd39: nq_r[3] <= 64'(q_r[3]) + tdt_s;
            default: ;
          endcase
        end
      end
      S_OUT: begin
        if (out_free) begin
          for (int k = 0; k < 4; k++) out_q_r[k] <= orient_r[k];
          out_skip_r <= skip_r;
        end
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("item accepted while another is in flight");

  a_quat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (out_if.quat_w <= QMAX && out_if.quat_w >= -QMAX &&
                      out_if.quat_z <= QMAX && out_if.quat_z >= -QMAX))
    else $error("quaternion component out of range");

  a_unit_done: assert property (@(posedge clk) disable iff (!rst_n)
    ut_stat.done |-> (state_r == S_ACC_WAIT || state_r == S_GRAD_WAIT ||
                      state_r == S_NQ_WAIT))
    else $error("normalization finished outside a wait state");
`endif

endmodule

// ----- design/imugd_unitize.sv -----
// ----------------------------------------------------------------------------
// imugd_unitize
// Normalizes a 4-vector to q30 unit length: scale search, sum of squares,
// bit-pair square root and restoring divide, one step per cycle.
// ----------------------------------------------------------------------------
module imugd_unitize (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  imugd_pkg::vec4_t    vec_in,
  output imugd_pkg::quat_t    un,
  output imugd_pkg::ut_stat_t stat
);
  import imugd_pkg::*;

  ut_state_t   ust_r, ust_nxt;
  logic [63:0] mag_r [4];
  logic        neg_r [4];
  logic [63:0] m_r;
  logic [5:0]  rsh_r, lsh_r;
  logic [63:0] sum_r;
  logic [28:0] s_r [4];
  logic [1:0]  k_r;
  logic [63:0] x_r, res_r, bit_r;
  logic [31:0] n_r;
  logic [31:0] rem_r;
  logic [30:0] num_r;
  logic [30:0] quo_r;
  logic [4:0]  cnt_r;
  logic [31:0] un_r [4];
  logic        ok_r;

  logic [63:0] vm [4];
  logic [63:0] vmax;
  logic [28:0] s_cur;
  logic [57:0] sq;
  logic [63:0] t_root;
  logic        ge_root;
  logic [63:0] res_nxt;
  logic [59:0] numer;
  logic [31:0] rem2;
  logic        ge_div;
  logic [30:0] quo_nxt;

  always_comb begin
    vmax = 64'd0;
    for (int k = 0; k < 4; k++) begin
      vm[k] = mag64(vec_in[k]);
      if (vm[k] > vmax) vmax = vm[k];
    end
  end

  assign s_cur   = 29'((mag_r[k_r] >> rsh_r) << lsh_r);
  assign sq      = 58'(s_cur) * 58'(s_cur);
  assign t_root  = res_r + bit_r;
  assign ge_root = x_r >= t_root;
  assign res_nxt = ge_root ? ((res_r >> 1) + bit_r) : (res_r >> 1);
  assign numer   = {s_r[k_r], 30'd0} + 60'(n_r >> 1);
  assign rem2    = {rem_r[30:0], num_r[30]};
  assign ge_div  = rem2 >= n_r;
  assign quo_nxt = {quo_r[29:0], ge_div};

  always_comb begin
    ust_nxt = ust_r;
    unique case (ust_r)
      U_IDLE:  if (start) ust_nxt = (vmax == 64'd0) ? U_DONE : U_SCALE;
      U_SCALE: if (m_r < 64'h2000_0000 && m_r >= 64'h1000_0000) ust_nxt = U_SQ;
      U_SQ:    if (k_r == 2'd3) ust_nxt = U_ROOT;
      U_ROOT:  if (bit_r == 64'd1) ust_nxt = U_DSET;
      U_DSET:  ust_nxt = U_DIV;
      U_DIV:   if (cnt_r == 5'd0) ust_nxt = (k_r == 2'd3) ? U_DONE : U_DSET;
      U_DONE:  ust_nxt = U_IDLE;
      default: ust_nxt = U_IDLE;
    endcase
  end

  always_comb begin
    stat.done = (ust_r == U_DONE);
    stat.ok   = ok_r;
    for (int k = 0; k < 4; k++) un[k] = un_r[k];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ust_r <= U_IDLE;
      ok_r  <= 1'b0;
    end else begin
      ust_r <= ust_nxt;
      unique case (ust_r)
        U_IDLE: begin
          if (start) begin
            for (int k = 0; k < 4; k++) begin
              mag_r[k] <= vm[k];
              neg_r[k] <= vec_in[k][63];
            end
            m_r   <= vmax;
            rsh_r <= 6'd0;
            lsh_r <= 6'd0;
            ok_r  <= (vmax != 64'd0);
          end
        end
        U_SCALE: begin
          if (m_r >= 64'h2000_0000) begin
            m_r   <= m_r >> 1;
            rsh_r <= rsh_r + 6'd1;
          end else if (m_r < 64'h1000_0000) begin
            m_r   <= m_r << 1;
            lsh_r <= lsh_r + 6'd1;
          end else begin
            k_r   <= 2'd0;
            sum_r <= 64'd0;
          end
        end
        U_SQ: begin
          s_r[k_r] <= s_cur;
          sum_r    <= sum_r + 64'(sq);
          k_r      <= k_r + 2'd1;
          if (k_r == 2'd3) begin
            x_r   <= sum_r + 64'(sq);
            res_r <= 64'd0;
            bit_r <= 64'd1 << 62;
          end
        end
        U_ROOT: begin
          if (ge_root) x_r <= x_r - t_root;
          res_r <= res_nxt;
          bit_r <= bit_r >> 2;
          if (bit_r == 64'd1) begin
            n_r <= res_nxt[31:0];
            k_r <= 2'd0;
          end
        end
        U_DSET: begin
          rem_r <= 32'(numer >> 31);
          num_r <= numer[30:0];
          quo_r <= 31'd0;
          cnt_r <= 5'd30;
        end
        U_DIV: begin
          rem_r <= ge_div ? (rem2 - n_r) : rem2;
          num_r <= num_r << 1;
          quo_r <= quo_nxt;
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == 5'd0) begin
            un_r[k_r] <= neg_r[k_r] ? (32'd0 - {1'b0, quo_nxt}) : {1'b0, quo_nxt};
            k_r       <= k_r + 2'd1;
          end
        end
        U_DONE: ;
        default: ;
      endcase
    end
  end

endmodule
